[sv/nnt_pkg.sv]
// Shared types and constants for the nearest neighbor tour block.
`timescale 1ns / 1ps

package nnt_pkg;

    localparam int COST_BITS     = 37;
    localparam int OUT_COST_BITS = 36;
    localparam int VCOUNT_BITS   = 6;

    localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET = 6'd32;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_SOLVE = 1'b1;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_START   = 2'd1;
    localparam logic [1:0] ERR_NO_PATH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STEP_END,
        ST_CLOSE_RD,
        ST_CLOSE_WAIT,
        ST_EMIT
    } nnt_state_t;

endpackage

[sv/nnt_dist_mem.sv]
// Distance matrix storage: one write port, one read port with registered data.
`timescale 1ns / 1ps

module nnt_dist_mem #(
    parameter int ADDR_BITS = 10,
    parameter int DATA_BITS = 31
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [1 << ADDR_BITS];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/nearest_neighbor_tour.sv]
// Greedy nearest neighbor tour builder over a loaded directed distance matrix.
//
//   channel   | signals                                         | direction
//   ----------+-------------------------------------------------+----------
//   request   | start, busy (out), req_type, row, col, weight,  | in
//             | start_vertex                                    |
//   result    | result_strobe, tour_vertex, last, tour_cost,    | out
//             | error_code                                      |
//   config    | cfg_we, cfg_wdata (vertex_count)                | in
//
// A load item does not raise busy. A solve item keeps busy high until it issues
// its last result; the single matrix read port scans one row entry per cycle for
// each of the n-1 steps of a tour over n vertices. A bad start gives its error
// item on the next cycle without raising busy. Results cannot be stalled. Reset
// initializes all control state; the matrix is undefined until loaded.
`timescale 1ns / 1ps

module nearest_neighbor_tour #(
    parameter int MAX_VERTICES = 32,
    parameter int WEIGHT_BITS  = 31
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                req_type,
    input  logic [4:0]                          row,
    input  logic [4:0]                          col,
    input  logic [30:0]                         weight,
    input  logic [4:0]                          start_vertex,
    input  logic                                cfg_we,
    input  logic [nnt_pkg::VCOUNT_BITS-1:0]     cfg_wdata,
    output logic                                result_strobe,
    output logic [4:0]                          tour_vertex,
    output logic                                last,
    output logic [nnt_pkg::OUT_COST_BITS-1:0]   tour_cost,
    output logic [1:0]                          error_code
);

    import nnt_pkg::*;

    localparam int VB = $clog2(MAX_VERTICES);
    localparam int NB = $clog2(MAX_VERTICES + 1);
    localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};

    nnt_state_t state_reg, state_next;

    logic [VCOUNT_BITS-1:0]   vcount_reg;
    logic [NB-1:0]            n_reg, n_next;
    logic [VB-1:0]            cur_reg, cur_next;
    logic [VB-1:0]            first_reg, first_next;
    logic [MAX_VERTICES-1:0]  visited_reg, visited_next;
    logic [COST_BITS-1:0]     cost_reg, cost_next;
    logic [NB-1:0]            step_reg, step_next;
    logic [NB-1:0]            addr_idx_reg, addr_idx_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [VB-1:0]            rd_idx_reg, rd_idx_next;
    logic [WEIGHT_BITS-1:0]   best_reg, best_next;
    logic [VB-1:0]            next_v_reg, next_v_next;
    logic                     found_reg, found_next;
    logic [VB-1:0]            emit_idx_reg, emit_idx_next;

    logic                     strobe_reg, strobe_next;
    logic [4:0]               vertex_reg, vertex_next;
    logic                     last_reg, last_next;
    logic [OUT_COST_BITS-1:0] ocost_reg, ocost_next;
    logic [1:0]               err_reg, err_next;

    logic [VB-1:0]            tour_mem [MAX_VERTICES];
    logic [VB-1:0]            tour_rd_reg;
    logic                     tour_we;
    logic [VB-1:0]            tour_waddr, tour_wdata, tour_raddr;

    logic                     mem_we;
    logic [2*VB-1:0]          mem_waddr, mem_raddr;
    logic [WEIGHT_BITS-1:0]   mem_rdata;

    logic [7:0]               row_w, col_w, start_w;
    logic [7:0]               vc_w;
    logic [NB-1:0]            n_eff;
    logic                     accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign row_w   = 8'(row);
    assign col_w   = 8'(col);
    assign start_w = 8'(start_vertex);
    assign vc_w    = 8'(vcount_reg);
    assign n_eff   = (vc_w > 8'(MAX_VERTICES)) ? NB'(MAX_VERTICES) : NB'(vc_w);

    assign mem_we    = accept && (req_type == REQ_LOAD) && (row_w < 8'(MAX_VERTICES))
                       && (col_w < 8'(MAX_VERTICES));
    assign mem_waddr = {row_w[VB-1:0], col_w[VB-1:0]};
    assign mem_raddr = (state_reg == ST_CLOSE_RD) ? {cur_reg, first_reg}
                                                  : {cur_reg, addr_idx_reg[VB-1:0]};

    nnt_dist_mem #(
        .ADDR_BITS (2 * VB),
        .DATA_BITS (WEIGHT_BITS)
    ) u_dist_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (weight[WEIGHT_BITS-1:0]),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (tour_we)
        begin
            tour_mem[tour_waddr] <= tour_wdata;
        end
        tour_rd_reg <= tour_mem[tour_raddr];
    end

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        cur_next      = cur_reg;
        first_next    = first_reg;
        visited_next  = visited_reg;
        cost_next     = cost_reg;
        step_next     = step_reg;
        addr_idx_next = addr_idx_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        best_next     = best_reg;
        next_v_next   = next_v_reg;
        found_next    = found_reg;
        emit_idx_next = emit_idx_reg;
        strobe_next   = 1'b0;
        vertex_next   = vertex_reg;
        last_next     = last_reg;
        ocost_next    = ocost_reg;
        err_next      = err_reg;
        tour_we       = 1'b0;
        tour_waddr    = step_reg[VB-1:0];
        tour_wdata    = next_v_reg;
        tour_raddr    = emit_idx_reg + VB'(1);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_SOLVE))
                begin
                    if (start_w >= 8'(n_eff))
                    begin
                        strobe_next = 1'b1;
                        vertex_next = 5'd0;
                        last_next   = 1'b1;
                        ocost_next  = '0;
                        err_next    = ERR_START;
                    end
                    else
                    begin
                        n_next        = n_eff;
                        cur_next      = start_w[VB-1:0];
                        first_next    = start_w[VB-1:0];
                        visited_next  = MAX_VERTICES'(1) << start_w[VB-1:0];
                        cost_next     = '0;
                        step_next     = NB'(1);
                        addr_idx_next = '0;
                        best_next     = WMAX;
                        found_next    = 1'b0;
                        tour_we       = 1'b1;
                        tour_waddr    = '0;
                        tour_wdata    = start_w[VB-1:0];
                        state_next    = (n_eff == NB'(1)) ? ST_CLOSE_RD : ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (addr_idx_reg < n_reg)
                begin
                    rd_vld_next   = 1'b1;
                    rd_idx_next   = addr_idx_reg[VB-1:0];
                    addr_idx_next = addr_idx_reg + NB'(1);
                end
                if (rd_vld_reg)
                begin
                    if (!visited_reg[rd_idx_reg] && (mem_rdata < best_reg))
                    begin
                        best_next   = mem_rdata;
                        next_v_next = rd_idx_reg;
                        found_next  = 1'b1;
                    end
                    if (NB'(rd_idx_reg) + NB'(1) == n_reg)
                    begin
                        state_next = ST_STEP_END;
                    end
                end
            end

            ST_STEP_END:
            begin
                if (!found_reg)
                begin
                    strobe_next = 1'b1;
                    vertex_next = 5'd0;
                    last_next   = 1'b1;
                    ocost_next  = '0;
                    err_next    = ERR_NO_PATH;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    visited_next  = visited_reg | (MAX_VERTICES'(1) << next_v_reg);
                    cost_next     = cost_reg + COST_BITS'(best_reg);
                    cur_next      = next_v_reg;
                    tour_we       = 1'b1;
                    step_next     = step_reg + NB'(1);
                    addr_idx_next = '0;
                    best_next     = WMAX;
                    found_next    = 1'b0;
                    state_next    = (step_reg + NB'(1) == n_reg) ? ST_CLOSE_RD : ST_SCAN;
                end
            end

            ST_CLOSE_RD:
            begin
                state_next = ST_CLOSE_WAIT;
            end

            ST_CLOSE_WAIT:
            begin
                cost_next     = cost_reg + COST_BITS'(mem_rdata);
                tour_raddr    = '0;
                emit_idx_next = '0;
                state_next    = ST_EMIT;
            end

            ST_EMIT:
            begin
                strobe_next   = 1'b1;
                vertex_next   = 5'(tour_rd_reg);
                err_next      = ERR_NONE;
                emit_idx_next = emit_idx_reg + VB'(1);
                if (NB'(emit_idx_reg) + NB'(1) == n_reg)
                begin
                    last_next  = 1'b1;
                    ocost_next = cost_reg[OUT_COST_BITS-1:0];
                    state_next = ST_IDLE;
                end
                else
                begin
                    last_next  = 1'b0;
                    ocost_next = '0;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            vcount_reg   <= VCOUNT_RESET;
            n_reg        <= '0;
            cur_reg      <= '0;
            first_reg    <= '0;
            visited_reg  <= '0;
            cost_reg     <= '0;
            step_reg     <= '0;
            addr_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            rd_idx_reg   <= '0;
            best_reg     <= WMAX;
            next_v_reg   <= '0;
            found_reg    <= 1'b0;
            emit_idx_reg <= '0;
            strobe_reg   <= 1'b0;
            vertex_reg   <= '0;
            last_reg     <= 1'b0;
            ocost_reg    <= '0;
            err_reg      <= ERR_NONE;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
            n_reg        <= n_next;
            cur_reg      <= cur_next;
            first_reg    <= first_next;
            visited_reg  <= visited_next;
            cost_reg     <= cost_next;
            step_reg     <= step_next;
            addr_idx_reg <= addr_idx_next;
            rd_vld_reg   <= rd_vld_next;
            rd_idx_reg   <= rd_idx_next;
            best_reg     <= best_next;
            next_v_reg   <= next_v_next;
            found_reg    <= found_next;
            emit_idx_reg <= emit_idx_next;
            strobe_reg   <= strobe_next;
            vertex_reg   <= vertex_next;
            last_reg     <= last_next;
            ocost_reg    <= ocost_next;
            err_reg      <= err_next;
        end
    end

    assign result_strobe = strobe_reg;
    assign tour_vertex   = vertex_reg;
    assign last          = last_reg;
    assign tour_cost     = ocost_reg;
    assign error_code    = err_reg;

endmodule

[tb/nnt_tour_checker.sv]
// Checker for the nearest neighbor tour block: predicts each tour item and compares results.
`timescale 1ns / 1ps

module nnt_tour_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              req_type,
    input  logic [4:0]                        row,
    input  logic [4:0]                        col,
    input  logic [30:0]                       weight,
    input  logic [4:0]                        start_vertex,
    input  logic                              cfg_we,
    input  logic [nnt_pkg::VCOUNT_BITS-1:0]   cfg_wdata,
    input  logic                              result_strobe,
    input  logic [4:0]                        tour_vertex,
    input  logic                              last,
    input  logic [nnt_pkg::OUT_COST_BITS-1:0] tour_cost,
    input  logic [1:0]                        error_code,
    output int                                fail_count,
    output int                                pending,
    output int                                checked
);

    import nnt_pkg::*;

    localparam int          MAX_V   = 32;
    localparam logic [30:0] NO_EDGE = '1;

    typedef struct packed {
        logic [4:0]               vertex;
        logic                     fin;
        logic [OUT_COST_BITS-1:0] cost;
        logic [1:0]               err;
    } tour_stop_t;

    logic [30:0]            edge_cost [MAX_V][MAX_V];
    logic [VCOUNT_BITS-1:0] vertex_limit;
    tour_stop_t             expected_stops [$];

    function automatic void queue_error(input logic [1:0] code);
        tour_stop_t s;
        s.vertex = 5'd0;
        s.fin    = 1'b1;
        s.cost   = '0;
        s.err    = code;
        expected_stops.insert(expected_stops.size(), s);
    endfunction

    // Greedy walk: strictly smallest unvisited edge, lowest index on ties.
    function automatic void plan_tour(input logic [4:0] origin);
        int                   n;
        int                   cur;
        int                   nxt;
        logic [30:0]          best;
        logic [MAX_V-1:0]     seen;
        logic [COST_BITS-1:0] total;
        logic [4:0]           order [MAX_V];
        tour_stop_t           s;
        n = (vertex_limit > MAX_V) ? MAX_V : int'(vertex_limit);
        if (int'(origin) >= n)
        begin
            queue_error(ERR_START);
            return;
        end
        seen         = '0;
        seen[origin] = 1'b1;
        cur          = int'(origin);
        total        = '0;
        order[0]     = origin;
        for (int k = 1; k < n; k++)
        begin
            best = NO_EDGE;
            nxt  = 0;
            for (int v = 0; v < n; v++)
            begin
                if (!seen[v] && edge_cost[cur][v] < best)
                begin
                    best = edge_cost[cur][v];
                    nxt  = v;
                end
            end
            if (best == NO_EDGE)
            begin
                queue_error(ERR_NO_PATH);
                return;
            end
            seen[nxt] = 1'b1;
            total     = total + COST_BITS'(best);
            cur       = nxt;
            order[k]  = nxt[4:0];
        end
        // closing edge counts even at the no-edge weight
        total = total + COST_BITS'(edge_cost[cur][origin]);
        for (int k = 0; k < n; k++)
        begin
            s.vertex = order[k];
            s.fin    = (k == n - 1);
            s.cost   = s.fin ? total[OUT_COST_BITS-1:0] : '0;
            s.err    = ERR_NONE;
            expected_stops.insert(expected_stops.size(), s);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tour_stop_t want;
        if (!rst_n)
        begin
            vertex_limit = VCOUNT_RESET;
            expected_stops.delete();
            pending    = 0;
            fail_count = 0;
            checked    = 0;
        end
        else
        begin
            if (result_strobe)
            begin
                if (expected_stops.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected tour item: vertex %0d last %0d cost %0d error %0d",
                             $time, tour_vertex, last, tour_cost, error_code);
                end
                else
                begin
                    want = expected_stops.pop_front();
                    checked++;
                    if (tour_vertex !== want.vertex || last !== want.fin ||
                        tour_cost !== want.cost || error_code !== want.err)
                    begin
                        fail_count++;
                        $display({"%0t: tour item mismatch: expected vertex %0d last %0d ",
                                  "cost %0d error %0d, got vertex %0d last %0d cost %0d error %0d"},
                                 $time, want.vertex, want.fin, want.cost, want.err,
                                 tour_vertex, last, tour_cost, error_code);
                    end
                end
            end
            if (cfg_we)
                vertex_limit = cfg_wdata;
            if (start && !busy)
            begin
                if (req_type == REQ_LOAD)
                    edge_cost[row][col] = weight;
                else
                    plan_tour(start_vertex);
            end
            pending = expected_stops.size();
        end
    end

endmodule

[tb/tb_nearest_neighbor_tour.sv]
// Testbench top for the nearest neighbor tour block: stimulus, run limit and verdict.
`timescale 1ns / 1ps

module tb_nearest_neighbor_tour;
    import nnt_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          RANDOM_ITEMS = 214;
    localparam int          LOADED       = 12;
    localparam logic [30:0] NO_EDGE      = '1;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic                     req_type;
    logic [4:0]               row;
    logic [4:0]               col;
    logic [30:0]              weight;
    logic [4:0]               start_vertex;
    logic                     cfg_we;
    logic [VCOUNT_BITS-1:0]   cfg_wdata;
    logic                     result_strobe;
    logic [4:0]               tour_vertex;
    logic                     last;
    logic [OUT_COST_BITS-1:0] tour_cost;
    logic [1:0]               error_code;

    int fail_count;
    int pending;
    int checked;
    int cycle_count;
    int items_sent;
    int solves_sent;
    int settings_written;
    bit steady;

    nearest_neighbor_tour dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .row           (row),
        .col           (col),
        .weight        (weight),
        .start_vertex  (start_vertex),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_strobe (result_strobe),
        .tour_vertex   (tour_vertex),
        .last          (last),
        .tour_cost     (tour_cost),
        .error_code    (error_code)
    );

    nnt_tour_checker tour_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .row           (row),
        .col           (col),
        .weight        (weight),
        .start_vertex  (start_vertex),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_strobe (result_strobe),
        .tour_vertex   (tour_vertex),
        .last          (last),
        .tour_cost     (tour_cost),
        .error_code    (error_code),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Mostly small weights so ties come up, plus the no-edge value and values near it.
    function automatic logic [30:0] draw_weight();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return 31'($urandom_range(0, 7));
        else if (pick < 55)
            return 31'($urandom_range(0, 300));
        else if (pick < 65)
            return NO_EDGE;
        else if (pick < 75)
            return NO_EDGE - 31'($urandom_range(1, 4));
        else
            return 31'($urandom);
    endfunction

    task automatic issue(input logic kind, input logic [4:0] src, input logic [4:0] dst,
                         input logic [30:0] w, input logic [4:0] origin);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        req_type     <= kind;
        row          <= src;
        col          <= dst;
        weight       <= w;
        start_vertex <= origin;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (kind == REQ_SOLVE)
            solves_sent++;
    endtask

    task automatic load_edge(input logic [4:0] src, input logic [4:0] dst, input logic [30:0] w);
        issue(REQ_LOAD, src, dst, w, 5'($urandom));
    endtask

    task automatic solve_from(input logic [4:0] origin);
        issue(REQ_SOLVE, 5'($urandom), 5'($urandom), 31'($urandom), origin);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_vertex_count(input logic [VCOUNT_BITS-1:0] n);
        wait_drained();
        cfg_wdata <= n;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_written++;
    endtask

    initial
    begin
        int                     target;
        int                     pick;
        int                     span;
        int                     lim;
        int                     ops;
        int                     dead;
        logic [VCOUNT_BITS-1:0] n_cfg;

        rst_n        <= 1'b0;
        start        <= 1'b0;
        req_type     <= REQ_LOAD;
        row          <= '0;
        col          <= '0;
        weight       <= '0;
        start_vertex <= '0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // top-left block first; solves read only it and row 31, so no unloaded entry is read
        steady = 1'b0;
        for (int r = 0; r < LOADED; r++)
            for (int c = 0; c < LOADED; c++)
                load_edge(r[4:0], c[4:0], draw_weight());

        // full size from reset: a row with no usable edge stops the walk at the first step
        for (int c = 0; c < 32; c++)
            load_edge(5'd31, c[4:0], NO_EDGE);
        solve_from(5'd31);

        // one vertex: closing self edge at the no-edge weight; bad starts
        set_vertex_count(6'd1);
        load_edge(5'd0, 5'd0, NO_EDGE);
        solve_from(5'd0);
        solve_from(5'd1);
        solve_from(5'd31);

        set_vertex_count(6'd0);
        solve_from(5'd0);

        set_vertex_count(6'd63);
        solve_from(5'd31);

        // dead end from vertex 0, then a tie at vertex 1 going to the lower index
        set_vertex_count(6'd3);
        load_edge(5'd0, 5'd1, NO_EDGE);
        load_edge(5'd0, 5'd2, NO_EDGE);
        solve_from(5'd0);
        load_edge(5'd1, 5'd0, 31'd5);
        load_edge(5'd1, 5'd2, 31'd5);
        load_edge(5'd0, 5'd2, 31'd7);
        load_edge(5'd2, 5'd1, 31'd0);
        solve_from(5'd1);
        solve_from(5'd2);

        set_vertex_count(6'd2);
        load_edge(5'd0, 5'd1, 31'd0);
        load_edge(5'd1, 5'd0, NO_EDGE - 31'd1);
        solve_from(5'd0);
        solve_from(5'd1);

        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                n_cfg = 6'd0;
            else if (pick < 10)
                n_cfg = 6'd1;
            else if (pick < 75)
                n_cfg = 6'($urandom_range(2, 8));
            else
                n_cfg = 6'($urandom_range(9, LOADED));
            set_vertex_count(n_cfg);
            steady = ($urandom_range(0, 3) == 0);
            span   = (n_cfg > 32) ? 32 : int'(n_cfg);
            lim    = (span == 0) ? 32 : span;
            ops    = (span > 16) ? $urandom_range(2, 5) : $urandom_range(3, 12);

            // a row with no usable edge gives a no-path error if reached before the last vertex
            if (span >= 2 && span <= 12 && $urandom_range(0, 4) == 0)
            begin
                dead = $urandom_range(0, span - 1);
                for (int c = 0; c < span; c++)
                    load_edge(dead[4:0], c[4:0], NO_EDGE);
                solve_from(5'($urandom_range(0, span - 1)));
            end

            for (int k = 0; k < ops; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    load_edge(5'($urandom_range(0, lim - 1)), 5'($urandom_range(0, lim - 1)),
                              draw_weight());
                else if (pick < 55)
                    load_edge(5'($urandom), 5'($urandom), draw_weight());
                else if (pick < 90)
                    solve_from(5'($urandom_range(0, lim - 1)));
                else
                    solve_from(5'($urandom));
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        @(negedge clk);

        $display("Sent %0d items (%0d solves) across %0d vertex_count writes, 0 through 63.",
                 items_sent, solves_sent, settings_written);
        $display("Compared %0d tour results covering ties, dead ends, bad starts and %0s",
                 checked, "tours of up to 12 vertices.");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
